// ----- rtl/serial_command_to_motor_servo_assert.svh -----
// Assertion macros shared by the serial command to motor servo design.
`ifndef SERIAL_COMMAND_TO_MOTOR_SERVO_ASSERT_SVH
`define SERIAL_COMMAND_TO_MOTOR_SERVO_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge outside reset.
`define SCMS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("scms assertion failed");
// A condition that must hold in the same cycle as its trigger.
`define SCMS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scms assertion failed");
// A condition that must hold in the cycle after its trigger.
`define SCMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scms assertion failed");
`else
`define SCMS_ASSERT_ALWAYS(label, clk, rst, cond)
`define SCMS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SCMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/scms_pkg.sv -----
// Shared types, constants and functions of the serial command to motor servo block.
`timescale 1ns / 1ps
package scms_pkg;

   // Default line capacity, including room for the terminator.
   localparam int LINE_CAPACITY_DEFAULT = 64;
   // Depth of the queue between the parser and the executor.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Character codes.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VTAB  = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_M_UP  = 8'h4D;
   localparam logic [7:0] CHAR_M_LO  = 8'h6D;
   localparam logic [7:0] CHAR_S_UP  = 8'h53;
   localparam logic [7:0] CHAR_S_LO  = 8'h73;

   // Target unit codes.
   localparam logic [1:0] UNIT_MOTOR_A   = 2'd0;
   localparam logic [1:0] UNIT_MOTOR_B   = 2'd1;
   localparam logic [1:0] UNIT_SERVO_ONE = 2'd2;
   localparam logic [1:0] UNIT_SERVO_TWO = 2'd3;

   // Motor direction codes.
   localparam logic [1:0] DIR_BRAKE   = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   // Identifiers of the two servos; ID_ONE also selects motor A.
   localparam logic [7:0] ID_ONE = 8'd1;
   localparam logic [7:0] ID_TWO = 8'd2;

   // Scaling constants.
   localparam logic [15:0] MAG_SATURATE = 16'hFFFF;
   localparam logic [15:0] SPEED_LIMIT  = 16'd100;
   localparam logic [15:0] ANGLE_LIMIT  = 16'd180;
   localparam logic [12:0] MOTOR_STEP   = 13'd72;
   localparam logic [12:0] SERVO_BASE   = 13'd500;
   // 2000/180 = 100/9; 100 * ceil(65536/9) keeps the floor exact for angles up to 180.
   localparam logic [19:0] SERVO_RECIP  = 20'd728200;
   localparam int          SERVO_SHIFT  = 16;

   // Grammar position within one line.
   typedef enum logic [3:0] {
      PH_LETTER,
      PH_WS1,
      PH_SIGN1,
      PH_DIG1,
      PH_WS2,
      PH_SIGN2,
      PH_DIG2,
      PH_DONE,
      PH_FAIL
   } phase_type;

   // One classified command line waiting to be carried out.
   typedef struct packed {
      logic        is_servo;
      logic [1:0]  unit;
      logic [15:0] magnitude;
      logic        negative;
   } command_type;

   // Write side of the queue.
   typedef struct packed {
      logic        valid;
      command_type command;
   } push_type;

   // Fill state of the queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Servo compare value for an angle of 0..180: 500 + angle * 2000 / 180.
   function automatic logic [12:0] servo_compare(input logic [7:0] angle);
      logic [27:0] product;
      begin
         product = 28'(angle) * 28'(SERVO_RECIP);
         return SERVO_BASE + 13'(product[27:SERVO_SHIFT]);
      end
   endfunction

endpackage

// ----- rtl/serial_command_to_motor_servo.sv -----
// A finished line's command goes into the command queue, then into the output register once it is free.
// Throughput: one received byte per cycle; one result per cycle from the output register while rsp_ready is high.
// The input stalls only while the two-entry command queue is full.
// Reset: synchronous, active high; clears the line, the queue and the output valid.
// Top level of the serial command to motor servo block.
`timescale 1ns / 1ps
module serial_command_to_motor_servo import scms_pkg::*; #(
   parameter int LineCapacity = LINE_CAPACITY_DEFAULT,
   parameter int QueueDepth   = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_target_unit,
   output logic [12:0] rsp_compare_value,
   output logic [1:0]  rsp_motor_direction
);

   push_type         push;
   logic             pop;
   command_type      head;
   queue_status_type status;

   // Parser and classifier.
   scms_front #(
      .LineCapacity(LineCapacity)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .queue_full (status.full),
      .push       (push)
   );

   // Command queue.
   scms_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .status(status)
   );

   // Set-point executor.
   scms_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .status             (status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target_unit    (rsp_target_unit),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_motor_direction(rsp_motor_direction)
   );

endmodule

// ----- rtl/scms_front.sv -----
// Line collector and parser that classifies complete command lines.
`timescale 1ns / 1ps
module scms_front import scms_pkg::*; #(
   parameter int LineCapacity = LINE_CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       queue_full,
   output push_type   push
);

   localparam int LEN_W = $clog2(LineCapacity);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LineCapacity - 1);

   logic [LEN_W-1:0] len_ff, len_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       letter_ff, letter_in;
   logic [7:0]       first_low_ff, first_low_in;
   logic             first_neg_ff, first_neg_in;
   logic [15:0]      mag_ff, mag_in;
   logic             second_neg_ff, second_neg_in;
   logic             success_ff, success_in;

   logic       accept;
   logic       is_term, is_blank, is_digit, is_sign, is_colon;
   logic [3:0] digit;
   logic       restart;
   logic [7:0] first_low_next;
   logic [19:0] mag_wide;
   logic [15:0] mag_next;
   logic [7:0] line_id;
   logic       is_motor, is_servo, id_is_one, id_is_two;

   // An item is taken whenever the queue can hold a finished line.
   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // Character classes.
   assign is_term  = (req_rx_byte == CHAR_LF) || (req_rx_byte == CHAR_CR);
   assign is_blank = (req_rx_byte == CHAR_SPACE) || (req_rx_byte == CHAR_TAB) ||
                     (req_rx_byte == CHAR_VTAB) || (req_rx_byte == CHAR_FF);
   assign is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
   assign is_sign  = (req_rx_byte == CHAR_PLUS) || (req_rx_byte == CHAR_MINUS);
   assign is_colon = (req_rx_byte == CHAR_COLON);
   assign digit    = req_rx_byte[3:0];

   // A terminator or an overflowing character starts the line afresh.
   assign restart = accept && (is_term || (len_ff == LEN_LIMIT));

   // Digit accumulation: the id keeps eight bits, the value saturates.
   assign first_low_next = 8'({first_low_ff, 3'b000}) + 8'({first_low_ff, 1'b0}) + 8'(digit);
   assign mag_wide = 20'({mag_ff, 3'b000}) + 20'({mag_ff, 1'b0}) + 20'(digit);
   assign mag_next = (mag_wide > 20'(MAG_SATURATE)) ? MAG_SATURATE : mag_wide[15:0];

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (restart) begin
         phase_in = PH_LETTER;
      end else if (accept) begin
         unique case (phase_ff)
            PH_LETTER: phase_in = PH_WS1;
            PH_WS1: begin
               if (is_blank)      phase_in = PH_WS1;
               else if (is_sign)  phase_in = PH_SIGN1;
               else if (is_digit) phase_in = PH_DIG1;
               else               phase_in = PH_FAIL;
            end
            PH_SIGN1: phase_in = is_digit ? PH_DIG1 : PH_FAIL;
            PH_DIG1: begin
               if (is_digit)      phase_in = PH_DIG1;
               else if (is_colon) phase_in = PH_WS2;
               else               phase_in = PH_FAIL;
            end
            PH_WS2: begin
               if (is_blank)      phase_in = PH_WS2;
               else if (is_sign)  phase_in = PH_SIGN2;
               else if (is_digit) phase_in = PH_DIG2;
               else               phase_in = PH_FAIL;
            end
            PH_SIGN2: phase_in = is_digit ? PH_DIG2 : PH_FAIL;
            PH_DIG2:  phase_in = is_digit ? PH_DIG2 : PH_DONE;
            PH_DONE:  phase_in = PH_DONE;
            PH_FAIL:  phase_in = PH_FAIL;
            default:  phase_in = PH_FAIL;
         endcase
      end
   end

   // Line contents that follow the phase.
   always_comb begin
      len_in        = len_ff;
      letter_in     = letter_ff;
      first_low_in  = first_low_ff;
      first_neg_in  = first_neg_ff;
      mag_in        = mag_ff;
      second_neg_in = second_neg_ff;
      success_in    = success_ff;
      if (restart) begin
         len_in        = '0;
         letter_in     = '0;
         first_low_in  = '0;
         first_neg_in  = 1'b0;
         mag_in        = '0;
         second_neg_in = 1'b0;
         success_in    = 1'b0;
      end else if (accept) begin
         len_in = len_ff + LEN_W'(1);
         unique case (phase_ff)
            PH_LETTER: letter_in = req_rx_byte;
            PH_WS1, PH_SIGN1, PH_DIG1: begin
               if (phase_ff == PH_WS1 && is_sign) begin
                  first_neg_in = (req_rx_byte == CHAR_MINUS);
               end else if (is_digit) begin
                  first_low_in = first_low_next;
               end
            end
            PH_WS2, PH_SIGN2, PH_DIG2: begin
               if (phase_ff == PH_WS2 && is_sign) begin
                  second_neg_in = (req_rx_byte == CHAR_MINUS);
               end else if (is_digit) begin
                  mag_in     = mag_next;
                  success_in = 1'b1;
               end
            end
            PH_DONE, PH_FAIL: begin
               len_in = len_ff + LEN_W'(1);
            end
            default: begin
               len_in = len_ff + LEN_W'(1);
            end
         endcase
      end
   end

   // Classification of a finished line.
   assign line_id   = first_neg_ff ? (8'd0 - first_low_ff) : first_low_ff;
   assign id_is_one = (line_id == ID_ONE);
   assign id_is_two = (line_id == ID_TWO);
   assign is_motor  = (letter_ff == CHAR_M_UP) || (letter_ff == CHAR_M_LO);
   assign is_servo  = (letter_ff == CHAR_S_UP) || (letter_ff == CHAR_S_LO);

   always_comb begin
      push.valid = accept && is_term && success_ff &&
                   (is_motor || (is_servo && (id_is_one || id_is_two)));
      push.command.is_servo  = !is_motor;
      push.command.magnitude = mag_ff;
      push.command.negative  = second_neg_ff;
      if (is_motor) begin
         push.command.unit = id_is_one ? UNIT_MOTOR_A : UNIT_MOTOR_B;
      end else begin
         push.command.unit = id_is_one ? UNIT_SERVO_ONE : UNIT_SERVO_TWO;
      end
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         phase_ff      <= PH_LETTER;
         letter_ff     <= '0;
         first_low_ff  <= '0;
         first_neg_ff  <= 1'b0;
         mag_ff        <= '0;
         second_neg_ff <= 1'b0;
         success_ff    <= 1'b0;
      end else begin
         len_ff        <= len_in;
         phase_ff      <= phase_in;
         letter_ff     <= letter_in;
         first_low_ff  <= first_low_in;
         first_neg_ff  <= first_neg_in;
         mag_ff        <= mag_in;
         second_neg_ff <= second_neg_in;
         success_ff    <= success_in;
      end
   end

endmodule

// ----- rtl/scms_queue.sv -----
// Short queue of classified commands between the parser and the executor.
`timescale 1ns / 1ps
`include "serial_command_to_motor_servo_assert.svh"
module scms_queue import scms_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output command_type      head,
   output queue_status_type status
);

   localparam int PTR_W   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int COUNT_W = $clog2(Depth + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(Depth - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(Depth);

   command_type        entries_ff [Depth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == COUNT_MAX);
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.command;
      end
   end

   `SCMS_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= COUNT_MAX)
   `SCMS_ASSERT_NEXT(a_push_grows, clock, reset, push.valid && !pop, count_ff == $past(count_ff) + COUNT_W'(1))

endmodule

// ----- rtl/scms_back.sv -----
// Executor that turns a queued command into a registered PWM set-point.
`timescale 1ns / 1ps
`include "serial_command_to_motor_servo_assert.svh"
module scms_back import scms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  command_type      head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_target_unit,
   output logic [12:0]      rsp_compare_value,
   output logic [1:0]       rsp_motor_direction
);

   logic        valid_ff, valid_in;
   logic [1:0]  unit_ff;
   logic [12:0] compare_ff, compare_in;
   logic [1:0]  dir_ff, dir_in;

   logic [6:0]  speed;
   logic [7:0]  angle;

   // A new command is loaded whenever the output register is free or draining.
   assign pop = !status.empty && (!valid_ff || rsp_ready);

   // Clamp the value to the range of each unit kind.
   assign speed = (head.magnitude > SPEED_LIMIT) ? 7'(SPEED_LIMIT) : head.magnitude[6:0];
   assign angle = head.negative ? 8'd0 :
                  ((head.magnitude > ANGLE_LIMIT) ? 8'(ANGLE_LIMIT) : head.magnitude[7:0]);

   // Compare value and direction.
   always_comb begin
      if (head.is_servo) begin
         compare_in = servo_compare(angle);
         dir_in     = DIR_BRAKE;
      end else begin
         compare_in = 13'(speed) * MOTOR_STEP;
         if (speed == '0)        dir_in = DIR_BRAKE;
         else if (head.negative) dir_in = DIR_REVERSE;
         else                    dir_in = DIR_FORWARD;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop)                        valid_in = 1'b1;
      else if (rsp_ready)             valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload, loaded with each popped command.
   always_ff @(posedge clock) begin
      if (pop) begin
         unit_ff    <= head.unit;
         compare_ff <= compare_in;
         dir_ff     <= dir_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_target_unit     = unit_ff;
   assign rsp_compare_value   = compare_ff;
   assign rsp_motor_direction = dir_ff;

   `SCMS_ASSERT_IMPLIES(a_compare_range, clock, reset, valid_ff, compare_ff <= 13'd7200)
   `SCMS_ASSERT_IMPLIES(a_servo_no_dir, clock, reset, valid_ff && unit_ff[1], dir_ff == DIR_BRAKE)

endmodule
